// ----- design/u8sd_pkg.sv -----
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int CP_W   = 31;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 3;

    typedef logic [CP_W-1:0]   t_cp;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_LEAD = 2'd1,
        ERR_CONT = 2'd2
    } t_err;

    typedef struct packed {
        t_cp  code_point;
        t_err error_kind;
        logic string_end;
    } t_result;

    // Lead and continuation byte patterns: mask, match value and payload mask
    localparam t_byte LEAD2_MASK = 8'hE0;
    localparam t_byte LEAD2_CODE = 8'hC0;
    localparam t_byte LEAD2_BITS = 8'h1F;
    localparam t_byte LEAD3_MASK = 8'hF0;
    localparam t_byte LEAD3_CODE = 8'hE0;
    localparam t_byte LEAD3_BITS = 8'h0F;
    localparam t_byte LEAD4_MASK = 8'hF8;
    localparam t_byte LEAD4_CODE = 8'hF0;
    localparam t_byte LEAD4_BITS = 8'h07;
    localparam t_byte LEAD5_MASK = 8'hFC;
    localparam t_byte LEAD5_CODE = 8'hF8;
    localparam t_byte LEAD5_BITS = 8'h03;
    localparam t_byte LEAD6_MASK = 8'hFE;
    localparam t_byte LEAD6_CODE = 8'hFC;
    localparam t_byte LEAD6_BITS = 8'h01;
    localparam t_byte CONT_MASK  = 8'hC0;
    localparam t_byte CONT_CODE  = 8'h80;
    localparam t_byte CONT_BITS  = 8'h3F;

    localparam t_cnt MAX_REMAINING = 3'd5;

endpackage

// ----- design/u8sd_in_reg.sv -----
`timescale 1ns / 1ps

module u8sd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  u8sd_pkg::t_byte i_byte,
    output logic            o_valid,
    input  logic            i_ready,
    output u8sd_pkg::t_byte o_byte
);

    logic            r_valid;
    u8sd_pkg::t_byte r_byte;

    // refill whenever the held item leaves or the stage is empty
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ----- design/u8sd_step.sv -----
`timescale 1ns / 1ps

module u8sd_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  u8sd_pkg::t_byte   i_byte,
    output logic              o_res_valid,
    output u8sd_pkg::t_result o_res
);

    u8sd_pkg::t_cp  r_partial;
    u8sd_pkg::t_cnt r_remaining;
    u8sd_pkg::t_cp  n_partial;
    u8sd_pkg::t_cnt n_remaining;
    u8sd_pkg::t_cp  shifted;

    assign shifted = {r_partial[u8sd_pkg::CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_partial   = r_partial;
        n_remaining = r_remaining;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_remaining != '0) begin
            if ((i_byte & u8sd_pkg::CONT_MASK) != u8sd_pkg::CONT_CODE) begin
                // drop the byte and the open sequence
                n_partial         = '0;
                n_remaining       = '0;
                o_res_valid       = 1'b1;
                o_res.error_kind  = u8sd_pkg::ERR_CONT;
            end else begin
                n_remaining = r_remaining - 3'd1;
                if (r_remaining == 3'd1) begin
                    n_partial        = '0;
                    o_res_valid      = 1'b1;
                    o_res.code_point = shifted;
                end else begin
                    n_partial = shifted;
                end
            end
        end else if (!i_byte[7]) begin
            o_res_valid      = 1'b1;
            o_res.code_point = u8sd_pkg::t_cp'(i_byte);
            o_res.string_end = (i_byte == '0);
        end else if ((i_byte & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_CODE) begin
            n_partial   = u8sd_pkg::t_cp'(i_byte & u8sd_pkg::LEAD2_BITS);
            n_remaining = 3'd1;
        end else if ((i_byte & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_CODE) begin
            n_partial   = u8sd_pkg::t_cp'(i_byte & u8sd_pkg::LEAD3_BITS);
            n_remaining = 3'd2;
        end else if ((i_byte & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_CODE) begin
            n_partial   = u8sd_pkg::t_cp'(i_byte & u8sd_pkg::LEAD4_BITS);
            n_remaining = 3'd3;
        end else if ((i_byte & u8sd_pkg::LEAD5_MASK) == u8sd_pkg::LEAD5_CODE) begin
            n_partial   = u8sd_pkg::t_cp'(i_byte & u8sd_pkg::LEAD5_BITS);
            n_remaining = 3'd4;
        end else if ((i_byte & u8sd_pkg::LEAD6_MASK) == u8sd_pkg::LEAD6_CODE) begin
            n_partial   = u8sd_pkg::t_cp'(i_byte & u8sd_pkg::LEAD6_BITS);
            n_remaining = u8sd_pkg::MAX_REMAINING;
        end else begin
            // stray continuation byte, 0xFE or 0xFF
            n_partial        = '0;
            o_res_valid      = 1'b1;
            o_res.error_kind = u8sd_pkg::ERR_LEAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_remaining <= '0;
        end else if (i_advance) begin
            r_partial   <= n_partial;
            r_remaining <= n_remaining;
        end
    end

    a_remaining_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= u8sd_pkg::MAX_REMAINING)
        else $error("continuation count out of range");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_remaining == '0) |-> (r_partial == '0))
        else $error("partial value not cleared in idle");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error_kind != u8sd_pkg::ERR_NONE) |->
        (o_res.code_point == '0 && !o_res.string_end))
        else $error("error result carries data");

    a_lead_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error_kind == u8sd_pkg::ERR_LEAD) |-> (r_remaining == '0))
        else $error("lead error raised mid-sequence");

endmodule

// ----- design/u8sd_out_reg.sv -----
`timescale 1ns / 1ps

module u8sd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  u8sd_pkg::t_result i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output u8sd_pkg::t_result o_res
);

    logic              r_valid;
    u8sd_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- design/utf8_stream_decoder.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_byte
// result    out        o_out_valid / i_out_ready  o_code_point, o_error_kind, o_string_end
//
// One byte per cycle sustained while the result side does not stall; a result
// passes through the input register, then is decoded into the result register.
// Lead bytes update the sequence state and produce no item.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// decoder to idle with a cleared partial value.
// A stalled result holds the result register; the input register still takes
// a byte while it is empty, and the decode step waits until the result
// register can take its output.

module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [30:0] o_code_point,
    output logic [1:0]  o_error_kind,
    output logic        o_string_end
);

    // input register -> decode
    logic              held_valid;
    u8sd_pkg::t_byte   held_byte;
    // decode -> result register
    logic              res_ready;
    logic              advance;
    logic              step_valid;
    u8sd_pkg::t_result step_res;
    u8sd_pkg::t_result out_res;

    u8sd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_in_byte),
        .o_valid (held_valid),
        .i_ready (res_ready),
        .o_byte  (held_byte)
    );

    // Consume the held byte only when the result register has room, so a
    // byte that completes a character never has to be parked.
    assign advance = held_valid && res_ready;

    u8sd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (held_byte),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    u8sd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance && step_valid),
        .o_ready (res_ready),
        .i_res   (step_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_code_point = out_res.code_point;
    assign o_error_kind = out_res.error_kind;
    assign o_string_end = out_res.string_end;

endmodule
